// File: design/pls_pkg.sv
package pls_pkg;

    // Field widths of the request and result transfers.
    localparam int POS_W    = 5;
    localparam int LEN_W    = 5;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;

    // Default list geometry.
    localparam int CAPACITY_DEFAULT  = 16;
    localparam int WORD_BITS_DEFAULT = 64;

    typedef enum logic [1:0] {
        REQ_READ      = 2'd0,
        REQ_OVERWRITE = 2'd1,
        REQ_INSERT    = 2'd2,
        REQ_DELETE    = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic en;
        req_t op;
    } cell_cmd_t;

endpackage

// File: design/pls_cell.sv
module pls_cell #(
    parameter int WORD_BITS = 64,
    parameter int IDX_W     = 4,
    parameter int IDX       = 0
) (
    input  logic                  aclk,
    input  pls_pkg::cell_cmd_t    cmd,
    input  logic [IDX_W-1:0]      k,
    input  logic [WORD_BITS-1:0]  wv,
    input  logic [WORD_BITS-1:0]  left_data,
    input  logic [WORD_BITS-1:0]  right_data,
    output logic [WORD_BITS-1:0]  data,
    output logic [WORD_BITS-1:0]  rd_data
);
    import pls_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;
    logic                 here;
    logic                 above;

    assign here  = (k == MY_IDX);
    assign above = (MY_IDX > k);

    always_comb begin
        data_next = data_reg;
        if (cmd.en) begin
            case (cmd.op)
                REQ_OVERWRITE: begin
                    if (here) data_next = wv;
                end
                REQ_INSERT: begin
                    if (here)       data_next = wv;
                    else if (above) data_next = left_data;
                end
                REQ_DELETE: begin
                    if (here || above) data_next = right_data;
                end
                default: data_next = data_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // Contributes to the read bus only when this cell is the addressed one.
    assign rd_data = data_reg & {WORD_BITS{here}};

endmodule

// File: design/positional_list_store.sv
// Positional list store: an ordered list of up to CAPACITY words, addressed by
// a 1-based position, kept in a row of cells where cell i holds position i+1. A
// request transfer reads, overwrites, inserts at, or deletes at one position;
// insert moves every later entry up one cell and delete moves every later
// entry down one cell, all cells shifting in the same clock. Each request
// returns exactly one result transfer carrying the read word (zero unless a
// read succeeded), a status (ok, position out of range, or list full) and the
// list length after the request. A request is decided and applied to the
// cells at the edge where it is accepted, and its result sits in the output
// register from the next cycle on. The input is ready whenever the output
// register is empty or is being emptied in the same cycle, so a sustained
// rate of one request per clock is reached when the result side keeps up.
// The length output is the entry count taken modulo 32, and only positions
// up to 31 can be addressed through the 5-bit position field.
module positional_list_store #(
    parameter int CAPACITY  = pls_pkg::CAPACITY_DEFAULT,
    parameter int WORD_BITS = pls_pkg::WORD_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_req_type,
    input  logic [pls_pkg::POS_W-1:0]    s_position,
    input  logic [pls_pkg::VALUE_W-1:0]  s_write_value,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pls_pkg::VALUE_W-1:0]  m_read_value,
    output logic [pls_pkg::STATUS_W-1:0] m_status,
    output logic [pls_pkg::LEN_W-1:0]    m_list_length
);
    import pls_pkg::*;

    // Cell index width, count width, and a compare width that holds both the
    // position field and the count plus one.
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // Control state.
    logic             m_valid_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Result register; payload needs no reset.
    logic [VALUE_W-1:0]  m_read_value_reg;
    logic [VALUE_W-1:0]  read_value_next;
    logic [STATUS_W-1:0] m_status_reg;
    status_t             status_next;
    logic [LEN_W-1:0]    m_list_length_reg;

    logic             accept;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] cnt_next_ext;
    logic             in_list;
    logic             in_insert;
    logic             is_full;
    logic             apply;
    req_t             req;
    logic [POS_W-1:0] pos_m1;
    logic [IDX_W-1:0] k;
    cell_cmd_t        cmd;
    logic [WORD_BITS-1:0] wv;
    logic [WORD_BITS-1:0] rd_or;

    logic [WORD_BITS-1:0] cell_data [CAPACITY];
    logic [WORD_BITS-1:0] cell_rd   [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign req     = req_t'(s_req_type);

    assign pos_ext   = CMP_W'(s_position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign in_list   = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign in_insert = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    assign is_full   = (count_reg >= CNT_FULL);

    // Zero-based cell index of the addressed entry. Whenever a request is
    // applied the position lies inside the row, so truncation loses nothing.
    assign pos_m1 = s_position - POS_W'(1);
    assign k      = IDX_W'(pos_m1);
    assign wv     = s_write_value[WORD_BITS-1:0];

    // The addressed cell alone drives its word onto the read bus.
    always_comb begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    // Request decode: decides status, read word, new count, and whether the cells change.
    always_comb begin
        status_next     = ST_OK;
        read_value_next = '0;
        count_next      = count_reg;
        apply           = 1'b0;
        case (req)
            REQ_READ: begin
                if (in_list) read_value_next = VALUE_W'(rd_or);
                else         status_next     = ST_BADPOS;
            end
            REQ_OVERWRITE: begin
                if (in_list) apply       = 1'b1;
                else         status_next = ST_BADPOS;
            end
            REQ_INSERT: begin
                if (!in_insert) begin
                    status_next = ST_BADPOS;
                end else if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    apply      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_DELETE: begin
                if (in_list) begin
                    apply      = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    status_next = ST_BADPOS;
                end
            end
            default: status_next = ST_BADPOS;
        endcase
    end

    assign cmd.en = accept && apply;
    assign cmd.op = req;

    // Row of cells: each takes its left neighbor on insert and its right
    // neighbor on delete. The top cell feeds itself on delete; whatever it
    // holds then lies beyond the count and is never read.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_BITS-1:0] left_in;
        logic [WORD_BITS-1:0] right_in;
        if (i == 0) begin : g_first
            assign left_in = wv;
        end else begin : g_mid_l
            assign left_in = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_in = cell_data[i];
        end else begin : g_mid_r
            assign right_in = cell_data[i+1];
        end
        pls_cell #(
            .WORD_BITS (WORD_BITS),
            .IDX_W     (IDX_W),
            .IDX       (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .k          (k),
            .wv         (wv),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    assign cnt_next_ext = CMP_W'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            if (accept) begin
                m_valid_reg <= 1'b1;
                count_reg   <= count_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_read_value_reg  <= read_value_next;
            m_status_reg      <= status_next;
            m_list_length_reg <= cnt_next_ext[LEN_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_status      = m_status_reg;
    assign m_list_length = m_list_length_reg;

endmodule

// File: design/pls_checker.sv
module pls_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [pls_pkg::VALUE_W-1:0]  m_read_value,
    input logic [pls_pkg::STATUS_W-1:0] m_status,
    input logic [pls_pkg::LEN_W-1:0]    m_list_length
);
    import pls_pkg::*;

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Every accepted request shows a result in the next cycle.
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request produced no result");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_BADPOS || m_status == ST_FULL))
        else $error("undefined status code");

    // A failed request never returns data.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_read_value == '0)
        else $error("failed request returned nonzero data");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_value)
            && $stable(m_status) && $stable(m_list_length))
        else $error("stalled result changed");

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);

// File: test/tb.sv
module tb;
    import pls_pkg::*;

    // The list geometry under test and the run guard. The slowest correct run
    // is roughly 800 requests, each behind a long sender gap and a long
    // receiver stall, plus two long receiver hold-offs, and the limit leaves a
    // wide margin over that run.
    localparam int LIST_CAP    = CAPACITY_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTED = 20;
    localparam int HOLD_CYCLES = 120;
    localparam int PHASE_COUNT = 15;
    localparam int PHASE_ITEMS = 50;

    // One request as the driver offers it. The gap is the number of idle cycles
    // placed before the request. When drain_first is set, the request is held
    // back until every outstanding result has come home.
    typedef struct {
        req_t               op;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        int                 gap;
        bit                 drain_first;
    } list_request_t;

    typedef struct {
        logic [VALUE_W-1:0] read_value;
        status_t            status;
        logic [LEN_W-1:0]   length;
    } list_result_t;

    // Every block input starts at a known value so that nothing floats
    // before the first clock edge.
    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_req_type    = 2'd0;
    logic [POS_W-1:0]     s_position    = '0;
    logic [VALUE_W-1:0]   s_write_value = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [VALUE_W-1:0]   m_read_value;
    logic [STATUS_W-1:0]  m_status;
    logic [LEN_W-1:0]     m_list_length;

    always #1 aclk = ~aclk;

    positional_list_store dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_position    (s_position),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_status      (m_status),
        .m_list_length (m_list_length)
    );

    // Pending stimulus and the results that are still owed by the block.
    list_request_t pending_requests [$];
    list_result_t  expected_results [$];
    list_request_t offered_request;

    // The predictor keeps its own copy of the list contents and its length.
    logic [VALUE_W-1:0] list_words [LIST_CAP];
    int list_count = 0;

    // The generator tracks the list length as well, so it can aim most
    // positions at the valid range and push the list to full and empty.
    int gen_length = 0;

    int total_requests = 0;
    int accepted_count = 0;
    int result_count   = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int idle_count     = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    int status_seen [3] = '{0, 0, 0};

    // Apply one accepted request to the predicted list and queue the result
    // that it must produce. Insert moves the entries from the position upward
    // one place up. Delete closes the gap by moving the later entries down.
    function automatic void predict_request(list_request_t req);
        list_result_t res;
        int p;
        res.read_value = '0;
        res.status     = ST_OK;
        p              = int'(req.pos);
        case (req.op)
            REQ_READ: begin
                if (p >= 1 && p <= list_count) res.read_value = list_words[p-1];
                else res.status = ST_BADPOS;
            end
            REQ_OVERWRITE: begin
                if (p >= 1 && p <= list_count) list_words[p-1] = req.value;
                else res.status = ST_BADPOS;
            end
            REQ_INSERT: begin
                if (p < 1 || p > list_count + 1) begin
                    res.status = ST_BADPOS;
                end else if (list_count >= LIST_CAP) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = list_count; i >= p; i--) list_words[i] = list_words[i-1];
                    list_words[p-1] = req.value;
                    list_count++;
                end
            end
            default: begin
                if (p >= 1 && p <= list_count) begin
                    for (int i = p; i < list_count; i++) list_words[i-1] = list_words[i];
                    list_count--;
                end else begin
                    res.status = ST_BADPOS;
                end
            end
        endcase
        res.length = LEN_W'(list_count);
        expected_results.push_back(res);
    endfunction

    // Every mismatch goes through here. The first few are printed, and all of
    // them are counted.
    task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                   logic [VALUE_W-1:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("MISMATCH at result %0d: %s got %h want %h",
                     result_count, what, got, want);
    endtask

    // Queue one request for the driver. The generator's length estimate is
    // updated alongside, so later positions can follow the list as it grows
    // and shrinks.
    task automatic add_request(req_t op, int pos, logic [VALUE_W-1:0] value,
                               int gap, bit drain_first);
        list_request_t req;
        req.op          = op;
        req.pos         = POS_W'(pos);
        req.value       = value;
        req.gap         = gap;
        req.drain_first = drain_first;
        pending_requests.push_back(req);
        total_requests++;
        if (op == REQ_INSERT && pos >= 1 && pos <= gen_length + 1 && gen_length < LIST_CAP)
            gen_length++;
        else if (op == REQ_DELETE && pos >= 1 && pos <= gen_length)
            gen_length--;
    endtask

    // Most positions fall in the range that the operation accepts, with the
    // ends of the range favored. The rest are drawn from the full 5-bit
    // field, which covers position zero and everything past the end.
    function automatic int pick_position(req_t op);
        int hi;
        hi = (op == REQ_INSERT) ? gen_length + 1 : gen_length;
        if (hi < 1 || $urandom_range(99) < 12) return $urandom_range(31);
        if ($urandom_range(99) < 10) return ($urandom_range(1) != 0) ? hi : 1;
        return $urandom_range(hi, 1);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '1;
        if (r < 10) return '0;
        return {$urandom, $urandom};
    endfunction

    // The sender's idle gaps are mostly short, with a few long ones. A quiet
    // phase offers requests back to back.
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(12, 4);
        return $urandom_range(50, 20);
    endfunction

    // The operation mix depends on the phase. A filling phase is heavy on
    // inserts, so the list reaches full. A draining phase is heavy on
    // deletes, so the list reaches empty. A mixed phase is even.
    function automatic req_t pick_op(int kind);
        int r;
        r = $urandom_range(99);
        case (kind)
            0: begin
                if (r < 60) return REQ_INSERT;
                if (r < 75) return REQ_READ;
                if (r < 88) return REQ_OVERWRITE;
                return REQ_DELETE;
            end
            2: begin
                if (r < 55) return REQ_DELETE;
                if (r < 70) return REQ_READ;
                if (r < 85) return REQ_OVERWRITE;
                return REQ_INSERT;
            end
            default: return req_t'(r % 4);
        endcase
    endfunction

    // The driver offers the request at the head of the pending queue. A new
    // request is loaded only when the channel is empty or the current
    // transfer completes at this edge. The valid signal therefore gets
    // at most one assignment per edge, and it stays high with a steady
    // payload until the block takes the transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_request(offered_request);
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (idle_count < pending_requests[0].gap) begin
                    idle_count++;
                    s_valid <= 1'b0;
                end else if (pending_requests[0].drain_first &&
                             expected_results.size() != 0) begin
                    s_valid <= 1'b0;
                end else begin
                    offered_request = pending_requests.pop_front();
                    idle_count      = 0;
                    s_req_type      <= offered_request.op;
                    s_position      <= offered_request.pos;
                    s_write_value   <= offered_request.value;
                    s_valid         <= 1'b1;
                end
            end
        end
    end

    // The monitor checks each result transfer against the oldest expectation,
    // and it decides the receiver's ready for the next cycle. Twice in the
    // run it holds off for a long stretch while the sender keeps offering
    // requests. The single output register fills, and the block has to stall
    // its input. In one window of a hundred results in every three hundred,
    // the receiver draws no new random stalls.
    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request outstanding", m_read_value, '0);
                end else begin
                    want = expected_results.pop_front();
                    status_seen[want.status]++;
                    if (m_read_value !== want.read_value)
                        report_mismatch("read_value", m_read_value, want.read_value);
                    if (m_status !== want.status)
                        report_mismatch("status", VALUE_W'(m_status), VALUE_W'(want.status));
                    if (m_list_length !== want.length)
                        report_mismatch("list_length", VALUE_W'(m_list_length),
                                        VALUE_W'(want.length));
                end
                if (result_count == 150 || result_count == 450) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (((result_count / 100) % 3) == 1 || $urandom_range(99) < 70) begin
                m_ready <= 1'b1;
            end else begin
                stall_left = ($urandom_range(99) < 85) ? $urandom_range(3) :
                             $urandom_range(40, 8);
                m_ready <= 1'b0;
            end
        end
    end

    // The timeout guard fails the run if it hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // The stimulus is built up front, then reset is released, and the run
    // ends once every transfer has been accepted and answered.
    initial begin
        int kind;
        bit quiet;
        req_t op;

        // Requests on an empty list. Every one of them is out of range,
        // including inserts at position zero and two past the end of the list.
        add_request(REQ_READ,      1, pick_value(), 0, 1'b0);
        add_request(REQ_OVERWRITE, 1, pick_value(), 0, 1'b0);
        add_request(REQ_DELETE,    1, pick_value(), 0, 1'b0);
        add_request(REQ_INSERT,    0, pick_value(), 0, 1'b0);
        add_request(REQ_INSERT,    2, pick_value(), 1, 1'b0);

        // Fill the list to capacity. The fill inserts all ones, then inserts
        // zero at the front, then appends at the end. The remaining inserts
        // go to random valid places.
        add_request(REQ_INSERT, 1, '1, 0, 1'b0);
        add_request(REQ_INSERT, 1, '0, 0, 1'b0);
        add_request(REQ_INSERT, 3, 64'hA5A5_5A5A_0FF0_F00F, 0, 1'b0);
        while (gen_length < LIST_CAP)
            add_request(REQ_INSERT, $urandom_range(gen_length + 1, 1), pick_value(), 0, 1'b0);

        // On a full list, an insert at a valid position reports full. One at
        // the top of the position field is out of range. Then come reads at zero
        // and at the end, a write at the end, and deletes at both ends.
        add_request(REQ_INSERT,    LIST_CAP + 1, pick_value(), 0, 1'b0);
        add_request(REQ_INSERT,    31,           pick_value(), 0, 1'b0);
        add_request(REQ_READ,      0,            pick_value(), 0, 1'b0);
        add_request(REQ_READ,      LIST_CAP,     pick_value(), 0, 1'b0);
        add_request(REQ_OVERWRITE, LIST_CAP,     '1,           0, 1'b0);
        add_request(REQ_DELETE,    LIST_CAP,     pick_value(), 0, 1'b0);
        add_request(REQ_DELETE,    1,            pick_value(), 0, 1'b0);

        // The random phases cycle through fill, mixed, drain and mixed. The
        // list therefore keeps swinging between full and empty. Two phases
        // open with a pause in which the sender waits for every result.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            kind  = ph % 4;
            quiet = (ph % 5) == 3;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = pick_op(kind);
                add_request(op, pick_position(op), pick_value(), pick_gap(quiet),
                            n == 0 && (ph == 6 || ph == 11));
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        wait (accepted_count == total_requests);
        wait (expected_results.size() == 0);
        repeat (8) @(posedge aclk);

        $display("Ran %0d list requests: %0d ok, %0d out of range, %0d list full.",
                 result_count, status_seen[ST_OK], status_seen[ST_BADPOS],
                 status_seen[ST_FULL]);
        $display("The list swung between empty and full under receiver hold-offs,");
        $display("sender drains and random gaps; %0d mismatches.", error_count);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
